// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Status and operation codes and the controller command bundle.
// ----------------------------------------------------------------------------
package spq_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_DUP   = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_EMPTY = 2'd3;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef struct packed {
    logic load;
    logic execute;
  } ctl_cmd_t;

endpackage

// ===== rtl/core/spq_req_if.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue request channel
// Valid/ready channel that carries one enqueue or dequeue item.
// ----------------------------------------------------------------------------
interface spq_req_if #(
  parameter int PRIO_BITS = 16,
  parameter int TAG_BITS  = 32
);
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [PRIO_BITS-1:0] prio;
  logic [TAG_BITS-1:0]  tag_in;

  modport source (output valid, output op, output prio, output tag_in, input ready);
  modport sink (input valid, input op, input prio, input tag_in, output ready);
endinterface

// ===== rtl/core/spq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue result channel
// Valid/ready channel that carries one result item per request.
// ----------------------------------------------------------------------------
interface spq_rsp_if #(
  parameter int TAG_BITS = 32,
  parameter int CNT_BITS = 5
);
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [TAG_BITS-1:0] tag_out;
  logic                tag_out_valid;
  logic [TAG_BITS-1:0] head_tag;
  logic                head_valid;
  logic [CNT_BITS-1:0] entry_count;

  modport source (output valid, output status, output tag_out, output tag_out_valid,
                  output head_tag, output head_valid, output entry_count, input ready);
  modport sink (input valid, input status, input tag_out, input tag_out_valid,
                input head_tag, input head_valid, input entry_count, output ready);
endinterface

// ===== rtl/core/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Two-state sequencer that captures an item, runs it once the result
// register is free, and tracks the result valid flag.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output spq_pkg::ctl_cmd_t cmd
);
  import spq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign in_ready    = (state_r == S_IDLE);
  assign slot_free   = !out_valid_r || out_ready;
  assign cmd.load    = in_valid && in_ready;
  assign cmd.execute = (state_r == S_EXEC) && slot_free;
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Row of sorted slot cells with per-cell compare, shift-in insert,
// shift-out removal and the registered result item.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int CAPACITY  = 16,
  parameter int PRIO_BITS = 16,
  parameter int TAG_BITS  = 32,
  parameter int OCC_W     = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spq_pkg::ctl_cmd_t    cmd,
  input  logic                 op,
  input  logic [PRIO_BITS-1:0] prio,
  input  logic [TAG_BITS-1:0]  tag_in,
  output spq_pkg::status_t     status,
  output logic [TAG_BITS-1:0]  tag_out,
  output logic                 tag_out_valid,
  output logic [TAG_BITS-1:0]  head_tag,
  output logic                 head_valid,
  output logic [OCC_W-1:0]     entry_count
);
  import spq_pkg::*;

  logic                 op_r;
  logic [PRIO_BITS-1:0] prio_r;
  logic [TAG_BITS-1:0]  tag_r;

  logic [PRIO_BITS-1:0] slot_prio_r [CAPACITY];
  logic [TAG_BITS-1:0]  slot_tag_r  [CAPACITY];
  logic [PRIO_BITS-1:0] slot_prio_nxt [CAPACITY];
  logic [TAG_BITS-1:0]  slot_tag_nxt  [CAPACITY];
  logic [OCC_W-1:0]     occ_r, occ_nxt;

  logic [CAPACITY-1:0]  gt, eq;
  logic                 dup, full, empty;
  status_t              st;

  status_t              status_r;
  logic [TAG_BITS-1:0]  tag_out_r, head_tag_r;
  logic                 tag_out_valid_r, head_valid_r;
  logic [OCC_W-1:0]     count_r;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (OCC_W'(i) < occ_r) && (slot_prio_r[i] > prio_r);
      eq[i] = (OCC_W'(i) < occ_r) && (slot_prio_r[i] == prio_r);
    end
  end

  assign dup   = |eq;
  assign full  = (occ_r == OCC_W'(CAPACITY));
  assign empty = (occ_r == '0);

  always_comb begin
    st      = ST_OK;
    occ_nxt = occ_r;
    for (int i = 0; i < CAPACITY; i++) begin
      slot_prio_nxt[i] = slot_prio_r[i];
      slot_tag_nxt[i]  = slot_tag_r[i];
    end
    if (op_r == OP_ENQ) begin
      if (dup) begin
        st = ST_DUP;
      end else if (full) begin
        st = ST_FULL;
      end else begin
        occ_nxt = occ_r + OCC_W'(1);
        for (int i = 0; i < CAPACITY; i++) begin
          if (!gt[i]) begin
            if (i == 0 || gt[(i == 0) ? 0 : i - 1]) begin
              slot_prio_nxt[i] = prio_r;
              slot_tag_nxt[i]  = tag_r;
            end else begin
              slot_prio_nxt[i] = slot_prio_r[(i == 0) ? 0 : i - 1];
              slot_tag_nxt[i]  = slot_tag_r[(i == 0) ? 0 : i - 1];
            end
          end
        end
      end
    end else begin
      if (empty) begin
        st = ST_EMPTY;
      end else begin
        occ_nxt = occ_r - OCC_W'(1);
        for (int i = 0; i < CAPACITY - 1; i++) begin
          slot_prio_nxt[i] = slot_prio_r[i + 1];
          slot_tag_nxt[i]  = slot_tag_r[i + 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op;
      prio_r <= prio;
      tag_r  <= tag_in;
    end
    if (cmd.execute) begin
      for (int i = 0; i < CAPACITY; i++) begin
        slot_prio_r[i] <= slot_prio_nxt[i];
        slot_tag_r[i]  <= slot_tag_nxt[i];
      end
      status_r        <= st;
      tag_out_valid_r <= (op_r == OP_DEQ) && !empty;
      tag_out_r       <= ((op_r == OP_DEQ) && !empty) ? slot_tag_r[0] : '0;
      head_valid_r    <= (occ_nxt != '0);
      head_tag_r      <= (occ_nxt != '0) ? slot_tag_nxt[0] : '0;
      count_r         <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (cmd.execute) begin
      occ_r <= occ_nxt;
    end
  end

  assign status        = status_r;
  assign tag_out       = tag_out_r;
  assign tag_out_valid = tag_out_valid_r;
  assign head_tag      = head_tag_r;
  assign head_valid    = head_valid_r;
  assign entry_count   = count_r;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(CAPACITY))
    else $error("occupancy exceeds capacity");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && (op_r == OP_DEQ) && !empty |=> occ_r == $past(occ_r) - OCC_W'(1))
    else $error("dequeue did not remove exactly one item");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && (op_r == OP_ENQ) && !dup && !full
    |=> occ_r == $past(occ_r) + OCC_W'(1))
    else $error("enqueue did not add exactly one item");

  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r >= OCC_W'(2) |-> slot_prio_r[0] > slot_prio_r[1])
    else $error("head slot is not the strict maximum");
`endif

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// A request item is captured into the item registers, then executed once the result
// register is free, and its result item is held in that register until taken.
// Items are accepted only in the idle state; a stalled result holds the execute step.
// A new item is accepted while the previous result still waits in its register.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
// Sorted priority queue top level
// Max-first queue of unique priorities with tags, kept in a sorted slot row.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int CAPACITY  = 16,
  parameter int PRIO_BITS = 16,
  parameter int TAG_BITS  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_req_if.sink   in_ch,
  spq_rsp_if.source out_ch
);
  import spq_pkg::*;

  localparam int OCC_W = $clog2(CAPACITY + 1);

  ctl_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  spq_datapath #(
    .CAPACITY  (CAPACITY),
    .PRIO_BITS (PRIO_BITS),
    .TAG_BITS  (TAG_BITS),
    .OCC_W     (OCC_W)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .op            (in_ch.op),
    .prio          (in_ch.prio),
    .tag_in        (in_ch.tag_in),
    .status        (out_ch.status),
    .tag_out       (out_ch.tag_out),
    .tag_out_valid (out_ch.tag_out_valid),
    .head_tag      (out_ch.head_tag),
    .head_valid    (out_ch.head_valid),
    .entry_count   (out_ch.entry_count)
  );

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives enqueue and dequeue items through the request channel and compares every
// result item with a mirror of the sorted queue kept in the bench, or with the
// table's result for items marked known. A short table of directed items comes
// first, followed by random traffic that swings between filling and draining the
// queue. The sender works in bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int PRIO_BITS   = 16;
  localparam int TAG_BITS    = 32;
  localparam int CNT_BITS    = 5;
  localparam int RAND_ITEMS  = 1900;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 8;

  typedef struct packed {
    status_t             status;
    logic [TAG_BITS-1:0] tag_out;
    logic                tag_out_valid;
    logic [TAG_BITS-1:0] head_tag;
    logic                head_valid;
    logic [CNT_BITS-1:0] entry_count;
  } result_t;

  typedef struct packed {
    logic                 op;
    logic [PRIO_BITS-1:0] prio;
    logic [TAG_BITS-1:0]  tag;
    logic                 known;
    result_t              res;
  } row_t;

  localparam result_t NO_RES = '0;
  localparam int PLAN_LEN = 27;

  localparam row_t PLAN [PLAN_LEN] = '{
    '{OP_DEQ, 16'h0000, 32'h0000_0000, 1'b1,
      '{ST_EMPTY, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, 5'd0}},
    '{OP_ENQ, 16'h0000, 32'h0000_0000, 1'b1,
      '{ST_OK, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b1, 5'd1}},
    '{OP_ENQ, 16'h0000, 32'hDEAD_BEEF, 1'b1,
      '{ST_DUP, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b1, 5'd1}},
    '{OP_ENQ, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
      '{ST_OK, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF, 1'b1, 5'd2}},
    '{OP_ENQ, 16'h8000, 32'h0000_0001, 1'b1,
      '{ST_OK, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF, 1'b1, 5'd3}},
    '{OP_DEQ, 16'h0000, 32'h0000_0000, 1'b1,
      '{ST_OK, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001, 1'b1, 5'd2}},
    '{OP_DEQ, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
      '{ST_OK, 32'h0000_0001, 1'b1, 32'h0000_0000, 1'b1, 5'd1}},
    '{OP_DEQ, 16'h0000, 32'h0000_0000, 1'b1,
      '{ST_OK, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 5'd0}},
    '{OP_DEQ, 16'h0000, 32'h0000_0000, 1'b1,
      '{ST_EMPTY, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, 5'd0}},
    '{OP_ENQ, 16'h0001, 32'h1111_0001, 1'b0, NO_RES},
    '{OP_ENQ, 16'hFFFE, 32'h2222_FFFE, 1'b0, NO_RES},
    '{OP_ENQ, 16'h7FFF, 32'h3333_7FFF, 1'b0, NO_RES},
    '{OP_ENQ, 16'h8001, 32'h4444_8001, 1'b0, NO_RES},
    '{OP_ENQ, 16'h00FF, 32'h5555_00FF, 1'b0, NO_RES},
    '{OP_ENQ, 16'hFF00, 32'h6666_FF00, 1'b0, NO_RES},
    '{OP_ENQ, 16'h5555, 32'hAAAA_5555, 1'b0, NO_RES},
    '{OP_ENQ, 16'hAAAA, 32'h5555_AAAA, 1'b0, NO_RES},
    '{OP_ENQ, 16'h0F0F, 32'hF0F0_0F0F, 1'b0, NO_RES},
    '{OP_ENQ, 16'hF0F0, 32'h0F0F_F0F0, 1'b0, NO_RES},
    '{OP_ENQ, 16'h1234, 32'h8765_1234, 1'b0, NO_RES},
    '{OP_ENQ, 16'hEDCB, 32'h789A_EDCB, 1'b0, NO_RES},
    '{OP_ENQ, 16'h0002, 32'h8000_0000, 1'b0, NO_RES},
    '{OP_ENQ, 16'hFFFD, 32'h7FFF_FFFF, 1'b0, NO_RES},
    '{OP_ENQ, 16'h4000, 32'hC3C3_4000, 1'b0, NO_RES},
    '{OP_ENQ, 16'hC000, 32'h3C3C_C000, 1'b0, NO_RES},
    '{OP_ENQ, 16'h3333, 32'h1357_9BDF, 1'b0, NO_RES},
    '{OP_ENQ, 16'hAAAA, 32'h2468_ACE0, 1'b0, NO_RES}
  };

  logic clk;
  logic rst_n;

  spq_req_if #(.PRIO_BITS(PRIO_BITS), .TAG_BITS(TAG_BITS)) req ();
  spq_rsp_if #(.TAG_BITS(TAG_BITS), .CNT_BITS(CNT_BITS)) rsp ();

  sorted_priority_queue #(
    .CAPACITY(CAPACITY),
    .PRIO_BITS(PRIO_BITS),
    .TAG_BITS(TAG_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(req),
    .out_ch(rsp)
  );

  logic [PRIO_BITS-1:0] mirror_prio [CAPACITY];
  logic [TAG_BITS-1:0]  mirror_tag [CAPACITY];
  int                   mirror_count;
  result_t              awaited_results [$];
  logic                 item_known;
  result_t              item_expect;
  int                   errors;
  int                   burst_left;
  int                   cycle_count;
  int                   stall_cycle;

  always #1 clk = ~clk;

  function automatic result_t apply_queue_op(logic op, logic [PRIO_BITS-1:0] p,
                                             logic [TAG_BITS-1:0] t);
    result_t r;
    int pos;
    r = '0;
    pos = 0;
    if (op == OP_ENQ) begin
      while (pos < mirror_count && mirror_prio[pos] > p) pos++;
      if (pos < mirror_count && mirror_prio[pos] == p) begin
        r.status = ST_DUP;
      end else if (mirror_count == CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        for (int i = mirror_count; i > pos; i--) begin
          mirror_prio[i] = mirror_prio[i-1];
          mirror_tag[i]  = mirror_tag[i-1];
        end
        mirror_prio[pos] = p;
        mirror_tag[pos]  = t;
        mirror_count++;
        r.status = ST_OK;
      end
    end else if (mirror_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status        = ST_OK;
      r.tag_out       = mirror_tag[0];
      r.tag_out_valid = 1'b1;
      for (int i = 1; i < mirror_count; i++) begin
        mirror_prio[i-1] = mirror_prio[i];
        mirror_tag[i-1]  = mirror_tag[i];
      end
      mirror_count--;
    end
    r.head_valid  = (mirror_count > 0);
    r.head_tag    = (mirror_count > 0) ? mirror_tag[0] : '0;
    r.entry_count = CNT_BITS'(mirror_count);
    return r;
  endfunction

  task automatic compare_result(result_t want, result_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
    if (got.tag_out !== want.tag_out) begin
      $error("tag_out: expected %h, got %h", want.tag_out, got.tag_out);
      errors++;
    end
    if (got.tag_out_valid !== want.tag_out_valid) begin
      $error("tag_out_valid: expected %0d, got %0d", want.tag_out_valid, got.tag_out_valid);
      errors++;
    end
    if (got.head_tag !== want.head_tag) begin
      $error("head_tag: expected %h, got %h", want.head_tag, got.head_tag);
      errors++;
    end
    if (got.head_valid !== want.head_valid) begin
      $error("head_valid: expected %0d, got %0d", want.head_valid, got.head_valid);
      errors++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
      errors++;
    end
  endtask

  task automatic send_item(logic op, logic [PRIO_BITS-1:0] p, logic [TAG_BITS-1:0] t,
                           logic known, result_t res);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req.valid   <= 1'b1;
    req.op      <= op;
    req.prio    <= p;
    req.tag_in  <= t;
    item_known  <= known;
    item_expect <= res;
    do @(posedge clk); while (!req.ready);
  endtask

  always @(posedge clk) begin : scoreboard
    result_t got;
    result_t want;
    if (rst_n && req.valid && req.ready) begin
      want = apply_queue_op(req.op, req.prio, req.tag_in);
      if (item_known) want = item_expect;
      awaited_results.push_back(want);
    end
    if (rst_n && rsp.valid && rsp.ready) begin
      got = '{rsp.status, rsp.tag_out, rsp.tag_out_valid, rsp.head_tag, rsp.head_valid,
              rsp.entry_count};
      if (awaited_results.size() == 0) begin
        $error("result item with no expected item waiting");
        errors++;
      end else begin
        want = awaited_results.pop_front();
        compare_result(want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** sorted_priority_queue: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    case ((stall_cycle / 300) % 4)
      0: rsp.ready <= 1'b1;
      1: rsp.ready <= ($urandom_range(0, 3) != 0);
      2: rsp.ready <= ((stall_cycle % 5) < 2);
      default: rsp.ready <= 1'($urandom_range(0, 1));
    endcase
    stall_cycle++;
  end

  initial begin
    int mode;
    int enq_weight;
    logic op;
    logic [PRIO_BITS-1:0] p;
    logic [TAG_BITS-1:0] t;
    clk          = 1'b0;
    rst_n        = 1'b0;
    req.valid    = 1'b0;
    req.op       = OP_ENQ;
    req.prio     = '0;
    req.tag_in   = '0;
    rsp.ready    = 1'b0;
    item_known   = 1'b0;
    item_expect  = '0;
    errors       = 0;
    burst_left   = 0;
    cycle_count  = 0;
    stall_cycle  = 0;
    mirror_count = 0;
    mode         = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < PLAN_LEN; n++) begin
      send_item(PLAN[n].op, PLAN[n].prio, PLAN[n].tag, PLAN[n].known, PLAN[n].res);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 120 == 0) mode = $urandom_range(0, 2);
      enq_weight = (mode == 0) ? 80 : (mode == 1) ? 25 : 55;
      op = ($urandom_range(0, 99) < enq_weight) ? OP_ENQ : OP_DEQ;
      p  = $urandom_range(0, 1) ? PRIO_BITS'($urandom_range(0, 40)) : PRIO_BITS'($urandom);
      t  = $urandom;
      send_item(op, p, t, 1'b0, NO_RES);
    end

    @(negedge clk);
    req.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("** sorted_priority_queue: PASSED **");
    end else begin
      $display("** sorted_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sorted_priority_queue.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_req_if.sv
rtl/core/spq_rsp_if.sv
rtl/core/spq_ctrl.sv
rtl/core/spq_datapath.sv
rtl/core/sorted_priority_queue.sv
bench/tb.sv
